/* hdl/pf_pkg.sv */
// Shared types, constants and helper functions for the Playfair digraph cipher unit.
package pf_pkg;

    localparam int LETTER_W = 5;
    localparam int SIDE     = 5;
    localparam int CELLS    = SIDE * SIDE;
    localparam int SQUARE_W = CELLS * LETTER_W;
    localparam int RC_W     = 3;
    localparam int WORD_W   = 50;
    localparam int THIRD_W  = 25;
    localparam int CFG_IDX_W = 3;

    localparam logic [LETTER_W-1:0] LETTER_I     = 5'd8;
    localparam logic [LETTER_W-1:0] LETTER_J     = 5'd9;
    localparam logic [LETTER_W-1:0] FILLER_RESET = 5'd23;
    localparam logic [LETTER_W-1:0] ALT_RESET    = 5'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SQUARE_FIRST  = 3'd0,
        CFG_SQUARE_SECOND = 3'd1,
        CFG_SQUARE_THIRD  = 3'd2,
        CFG_DECRYPT_MODE  = 3'd3,
        CFG_FILLER        = 3'd4,
        CFG_ALT_FILLER    = 3'd5
    } cfg_addr_t;

    // One digraph waiting to be mapped through the square.
    typedef struct packed {
        logic [LETTER_W-1:0] first;
        logic [LETTER_W-1:0] second;
        logic                last;
        logic                err;
    } pf_job_t;

    // Status of the pairing stage as seen by the top level.
    typedef struct packed {
        logic job_valid;
        logic two_pending;
    } pf_status_t;

    // The letter j shares the square cell of i.
    function automatic logic [LETTER_W-1:0] canon(input logic [LETTER_W-1:0] l);
        canon = (l == LETTER_J) ? LETTER_I : l;
    endfunction

    // Filler that splits or pads the given letter.
    function automatic logic [LETTER_W-1:0] pad_for(input logic [LETTER_W-1:0] l,
                                                    input logic [LETTER_W-1:0] filler,
                                                    input logic [LETTER_W-1:0] alt);
        logic [LETTER_W-1:0] f;
        f = canon(filler);
        pad_for = (l == f) ? canon(alt) : f;
    endfunction

    // Step a row or column index by one, forward or backward, modulo the side.
    function automatic logic [RC_W-1:0] step5(input logic [RC_W-1:0] v, input logic back);
        logic [RC_W-1:0] r;
        r = '0;
        case (v)
            3'd0:    r = back ? 3'd4 : 3'd1;
            3'd1:    r = back ? 3'd0 : 3'd2;
            3'd2:    r = back ? 3'd1 : 3'd3;
            3'd3:    r = back ? 3'd2 : 3'd4;
            3'd4:    r = back ? 3'd3 : 3'd0;
            default: r = '0;
        endcase
        step5 = r;
    endfunction

endpackage

/* hdl/pf_pair.sv */
// Pairing stage: forms digraphs from the letter stream and holds up to two pending jobs.
module pf_pair (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [pf_pkg::LETTER_W-1:0] letter,
    input  logic                        end_of_text,
    input  logic                        decrypt_mode,
    input  logic [pf_pkg::LETTER_W-1:0] filler_letter,
    input  logic [pf_pkg::LETTER_W-1:0] alt_filler_letter,
    input  logic                        move,
    output pf_pkg::pf_job_t             job,
    output pf_pkg::pf_status_t          status
);
    import pf_pkg::*;

    logic [LETTER_W-1:0] held_letter_reg, held_letter_next;
    logic                held_valid_reg, held_valid_next;
    pf_job_t             job0_reg, job1_reg;
    logic                job0_valid_reg, job1_valid_reg;

    pf_job_t             new0, new1;
    logic                new0_valid, new1_valid;
    logic                can_take, accept;
    logic [LETTER_W-1:0] l;

    assign can_take = !job1_valid_reg && (!job0_valid_reg || move);
    assign in_stall = !can_take;
    assign accept   = in_valid && can_take;
    assign l        = canon(letter);

    always_comb
    begin
        new0             = '0;
        new1             = '0;
        new0_valid       = 1'b0;
        new1_valid       = 1'b0;
        held_letter_next = held_letter_reg;
        held_valid_next  = held_valid_reg;
        if (accept)
        begin
            if (decrypt_mode)
            begin
                if (held_valid_reg)
                begin
                    new0             = '{first: held_letter_reg, second: l,
                                         last: end_of_text, err: 1'b0};
                    new0_valid       = 1'b1;
                    held_valid_next  = 1'b0;
                    held_letter_next = '0;
                end
                else if (end_of_text)
                begin
                    new0             = '{first: '0, second: '0, last: 1'b1, err: 1'b1};
                    new0_valid       = 1'b1;
                    held_letter_next = '0;
                end
                else
                begin
                    held_letter_next = l;
                    held_valid_next  = 1'b1;
                end
            end
            else if (held_valid_reg && (l != held_letter_reg))
            begin
                new0             = '{first: held_letter_reg, second: l,
                                     last: end_of_text, err: 1'b0};
                new0_valid       = 1'b1;
                held_valid_next  = 1'b0;
                held_letter_next = '0;
            end
            else
            begin
                // A doubled letter is split first; the new letter then starts a pair.
                if (held_valid_reg)
                begin
                    new0 = '{first: held_letter_reg,
                             second: pad_for(held_letter_reg, filler_letter,
                                             alt_filler_letter),
                             last: 1'b0, err: 1'b0};
                    new0_valid = 1'b1;
                end
                if (end_of_text)
                begin
                    if (held_valid_reg)
                    begin
                        new1 = '{first: l,
                                 second: pad_for(l, filler_letter, alt_filler_letter),
                                 last: 1'b1, err: 1'b0};
                        new1_valid = 1'b1;
                    end
                    else
                    begin
                        new0 = '{first: l,
                                 second: pad_for(l, filler_letter, alt_filler_letter),
                                 last: 1'b1, err: 1'b0};
                        new0_valid = 1'b1;
                    end
                    held_valid_next  = 1'b0;
                    held_letter_next = '0;
                end
                else
                begin
                    held_letter_next = l;
                    held_valid_next  = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_letter_reg <= '0;
            held_valid_reg  <= 1'b0;
            job0_valid_reg  <= 1'b0;
            job1_valid_reg  <= 1'b0;
        end
        else
        begin
            held_letter_reg <= held_letter_next;
            held_valid_reg  <= held_valid_next;
            if (accept)
            begin
                job0_valid_reg <= new0_valid;
                job1_valid_reg <= new1_valid;
            end
            else if (move)
            begin
                job0_valid_reg <= job1_valid_reg;
                job1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job0_reg <= new0;
            job1_reg <= new1;
        end
        else if (move)
        begin
            job0_reg <= job1_reg;
        end
    end

    assign job                = job0_reg;
    assign status.job_valid   = job0_valid_reg;
    assign status.two_pending = job1_valid_reg;

endmodule

/* hdl/pf_map.sv */
// Square lookup: locates both letters of a digraph and applies the Playfair rules.
module pf_map (
    input  logic [pf_pkg::SQUARE_W-1:0] square,
    input  logic                        decrypt_mode,
    input  pf_pkg::pf_job_t             job,
    output logic [pf_pkg::LETTER_W-1:0] out_first,
    output logic [pf_pkg::LETTER_W-1:0] out_second
);
    import pf_pkg::*;

    logic [LETTER_W-1:0] cells [CELLS];
    logic [RC_W-1:0]     r1, c1, r2, c2;
    logic [RC_W-1:0]     nr1, nc1, nr2, nc2;
    logic [LETTER_W-1:0] idx1, idx2;

    always_comb
    begin
        for (int k = 0; k < CELLS; k++)
        begin
            cells[k] = square[k*LETTER_W +: LETTER_W];
        end
    end

    // Descending scan so that the lowest matching cell wins; no match gives cell 0.
    always_comb
    begin
        r1 = '0;
        c1 = '0;
        r2 = '0;
        c2 = '0;
        for (int r = SIDE - 1; r >= 0; r--)
        begin
            for (int c = SIDE - 1; c >= 0; c--)
            begin
                if (cells[r*SIDE + c] == job.first)
                begin
                    r1 = RC_W'(r);
                    c1 = RC_W'(c);
                end
                if (cells[r*SIDE + c] == job.second)
                begin
                    r2 = RC_W'(r);
                    c2 = RC_W'(c);
                end
            end
        end
    end

    always_comb
    begin
        nr1 = r1;
        nc1 = c1;
        nr2 = r2;
        nc2 = c2;
        if (r1 == r2)
        begin
            nc1 = step5(c1, decrypt_mode);
            nc2 = step5(c2, decrypt_mode);
        end
        else if (c1 == c2)
        begin
            nr1 = step5(r1, decrypt_mode);
            nr2 = step5(r2, decrypt_mode);
        end
        else
        begin
            nc1 = c2;
            nc2 = c1;
        end
    end

    assign idx1 = LETTER_W'(nr1) * LETTER_W'(SIDE) + LETTER_W'(nc1);
    assign idx2 = LETTER_W'(nr2) * LETTER_W'(SIDE) + LETTER_W'(nc2);

    assign out_first  = job.err ? '0 : cells[idx1];
    assign out_second = job.err ? '0 : cells[idx2];

endmodule

/* hdl/playfair_digraph_cipher_unit.sv */
// Top level of the Playfair digraph cipher unit: configuration, pairing, mapping, output register.
//
// Usage: letters (0 to 25, j folded onto i) enter one word at a time on the input
// channel (in_valid, in_stall, letter, end_of_text). Each output word carries one
// mapped digraph (out_first, out_second), last_pair on the final digraph of a
// message, and odd_error when a decrypted message had an odd letter count.
// The 5x5 square, mode and fillers are written through the configuration channel
// (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is always high, and
// writes are expected only while no message is in flight.
// A digraph completed by an accepted letter is held in the pending-job register and
// moves into the output register when that register is free, which raises out_valid.
// Throughput: one letter per cycle while in_stall is low; a letter that releases
// two digraphs (a doubled pair closing the message in encrypt mode) holds the
// input off until the second digraph has moved on, since the pending-job register
// drains one digraph per cycle into the output register while that register is free.
// When the receiver raises out_stall the output word holds, the pending jobs wait,
// and in_stall rises once the pending-job register cannot take a new letter.
// Reset clears the held letter, all pending jobs and the output valid, and loads
// the configuration defaults (empty square, encrypt, filler x, second filler q).
module playfair_digraph_cipher_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [pf_pkg::LETTER_W-1:0]   letter,
    input  logic                          end_of_text,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [pf_pkg::LETTER_W-1:0]   out_first,
    output logic [pf_pkg::LETTER_W-1:0]   out_second,
    output logic                          last_pair,
    output logic                          odd_error,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pf_pkg::WORD_W-1:0]     cfg_data
);
    import pf_pkg::*;

    // Configuration registers.
    logic [WORD_W-1:0]   square_first_reg;
    logic [WORD_W-1:0]   square_second_reg;
    logic [THIRD_W-1:0]  square_third_reg;
    logic                decrypt_mode_reg;
    logic [LETTER_W-1:0] filler_reg;
    logic [LETTER_W-1:0] alt_filler_reg;

    // Output register.
    logic                out_valid_reg;
    logic [LETTER_W-1:0] out_first_reg, out_second_reg;
    logic                last_pair_reg, odd_error_reg;

    pf_job_t             job;
    pf_status_t          status;
    logic                move;
    logic [LETTER_W-1:0] map_first, map_second;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            square_first_reg  <= '0;
            square_second_reg <= '0;
            square_third_reg  <= '0;
            decrypt_mode_reg  <= 1'b0;
            filler_reg        <= FILLER_RESET;
            alt_filler_reg    <= ALT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_SQUARE_FIRST:  square_first_reg  <= cfg_data;
                CFG_SQUARE_SECOND: square_second_reg <= cfg_data;
                CFG_SQUARE_THIRD:  square_third_reg  <= cfg_data[THIRD_W-1:0];
                CFG_DECRYPT_MODE:  decrypt_mode_reg  <= cfg_data[0];
                CFG_FILLER:        filler_reg        <= cfg_data[LETTER_W-1:0];
                CFG_ALT_FILLER:    alt_filler_reg    <= cfg_data[LETTER_W-1:0];
                default:           ;
            endcase
        end
    end

    // A pending digraph moves into the output register whenever that register is
    // empty or its word is being taken in this cycle.
    assign move = status.job_valid && (!out_valid_reg || !out_stall);

    pf_pair u_pair (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .letter            (letter),
        .end_of_text       (end_of_text),
        .decrypt_mode      (decrypt_mode_reg),
        .filler_letter     (filler_reg),
        .alt_filler_letter (alt_filler_reg),
        .move              (move),
        .job               (job),
        .status            (status)
    );

    pf_map u_map (
        .square       ({square_third_reg, square_second_reg, square_first_reg}),
        .decrypt_mode (decrypt_mode_reg),
        .job          (job),
        .out_first    (map_first),
        .out_second   (map_second)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_first_reg  <= map_first;
            out_second_reg <= map_second;
            last_pair_reg  <= job.last;
            odd_error_reg  <= job.err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_first  = out_first_reg;
    assign out_second = out_second_reg;
    assign last_pair  = last_pair_reg;
    assign odd_error  = odd_error_reg;

    // An odd-length error word always closes the message and carries no letters.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && odd_error_reg) |-> (last_pair_reg && out_first_reg == '0
                                              && out_second_reg == '0))
        else $error("odd_error word is not a closing empty digraph");

    // The input is never open while a second digraph is still pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.two_pending |-> in_stall)
        else $error("input open with two digraphs pending");

    // A digraph handed to the output register is presented in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        move |=> out_valid_reg)
        else $error("moved digraph not presented");

    // A second pending digraph only exists behind a first one.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.two_pending |-> status.job_valid)
        else $error("second digraph pending without a first");

endmodule
